[src/ile_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed list engine package
// shared types, operation and status codes for the list engine
// ----------------------------------------------------------------------------
package ile_pkg;

  localparam int CapacityDef = 64;

  // operation codes of the kind field
  localparam logic [2:0] KIND_GET    = 3'd0;
  localparam logic [2:0] KIND_INSERT = 3'd1;
  localparam logic [2:0] KIND_FIND   = 3'd2;
  localparam logic [2:0] KIND_REMOVE = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // result status codes
  localparam logic [2:0] STATUS_OK      = 3'd0;
  localparam logic [2:0] STATUS_RANGE   = 3'd1;
  localparam logic [2:0] STATUS_NEG     = 3'd2;
  localparam logic [2:0] STATUS_FULL    = 3'd3;
  localparam logic [2:0] STATUS_MISSING = 3'd4;

  // memory walk performed by the sequencer
  typedef enum logic [1:0] {
    WALK_READ   = 2'd0,
    WALK_INSERT = 2'd1,
    WALK_FIND   = 2'd2,
    WALK_REMOVE = 2'd3
  } ile_walk_e;

  typedef struct packed {
    logic done;
    logic hit;
  } ile_stat_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         position;
    logic signed [31:0] value;
  } ile_req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data;
    logic [5:0]         found_at;
    logic [6:0]         count_after;
  } ile_res_t;

endpackage

[src/ile_walk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed list engine memory walker
// entry memory with registered read and a read-shift-write sequencer
// ----------------------------------------------------------------------------
module ile_walk #(
  parameter int CAPACITY = ile_pkg::CapacityDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  ile_pkg::ile_walk_e             op_i,
  input  logic [$clog2(CAPACITY)-1:0]    pos_i,
  input  logic [$clog2(CAPACITY+1)-1:0]  cnt_i,
  input  logic [31:0]                    value_i,
  output ile_pkg::ile_stat_t             stat_o,
  output logic [31:0]                    data_o,
  output logic [$clog2(CAPACITY)-1:0]    idx_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [1:0] W_IDLE  = 2'd0;
  localparam logic [1:0] W_RUN   = 2'd1;
  localparam logic [1:0] W_FINAL = 2'd2;

  logic [31:0] mem_q [CAPACITY];
  logic [31:0] rdata_q;

  logic [1:0]         state_q, state_d;
  ile_pkg::ile_walk_e op_q, op_d;
  logic [AW-1:0]      rptr_q, rptr_d;
  logic [AW-1:0]      stop_q, stop_d;
  logic [AW-1:0]      paddr_q, paddr_d;
  logic [AW-1:0]      pos_q, pos_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [31:0]        val_q, val_d;
  logic [31:0]        data_q, data_d;
  logic               more_q, more_d;
  logic               pend_q, pend_d;
  logic               done_q, done_d;
  logic               hit_q, hit_d;

  logic          re, we;
  logic [AW-1:0] raddr, waddr;
  logic [31:0]   wdata;
  logic [CW-1:0] cnt_m1;

  assign cnt_m1 = cnt_i - 1'b1;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    rptr_d  = rptr_q;
    stop_d  = stop_q;
    paddr_d = rptr_q;
    pos_d   = pos_q;
    idx_d   = idx_q;
    val_d   = val_q;
    data_d  = data_q;
    more_d  = more_q;
    pend_d  = 1'b0;
    done_d  = 1'b0;
    hit_d   = 1'b0;
    re      = 1'b0;
    raddr   = rptr_q;
    we      = 1'b0;
    waddr   = paddr_q;
    wdata   = rdata_q;
    unique case (state_q)
      W_IDLE: begin
        if (go_i) begin
          op_d  = op_i;
          pos_d = pos_i;
          val_d = value_i;
          unique case (op_i)
            ile_pkg::WALK_READ: begin
              rptr_d  = pos_i;
              stop_d  = pos_i;
              more_d  = 1'b1;
              state_d = W_RUN;
            end
            ile_pkg::WALK_INSERT: begin
              if (cnt_i == CW'(pos_i)) begin
                more_d  = 1'b0;
                state_d = W_FINAL;
              end else begin
                // move the tail up, highest entry first
                rptr_d  = cnt_m1[AW-1:0];
                stop_d  = pos_i;
                more_d  = 1'b1;
                state_d = W_RUN;
              end
            end
            ile_pkg::WALK_FIND: begin
              if (cnt_i == '0) begin
                done_d = 1'b1;
              end else begin
                rptr_d  = '0;
                stop_d  = cnt_m1[AW-1:0];
                more_d  = 1'b1;
                state_d = W_RUN;
              end
            end
            ile_pkg::WALK_REMOVE: begin
              rptr_d  = pos_i;
              stop_d  = cnt_m1[AW-1:0];
              more_d  = 1'b1;
              state_d = W_RUN;
            end
            default: state_d = W_IDLE;
          endcase
        end
      end
      W_RUN: begin
        re     = more_q;
        pend_d = more_q;
        if (more_q) begin
          if (rptr_q == stop_q) begin
            more_d = 1'b0;
          end else if (op_q == ile_pkg::WALK_INSERT) begin
            rptr_d = rptr_q - 1'b1;
          end else begin
            rptr_d = rptr_q + 1'b1;
          end
        end
        // rdata_q holds the entry at paddr_q
        if (pend_q) begin
          unique case (op_q)
            ile_pkg::WALK_READ: begin
              data_d  = rdata_q;
              done_d  = 1'b1;
              state_d = W_IDLE;
            end
            ile_pkg::WALK_INSERT: begin
              we    = 1'b1;
              waddr = paddr_q + 1'b1;
              if (!more_q) begin
                state_d = W_FINAL;
              end
            end
            ile_pkg::WALK_REMOVE: begin
              if (paddr_q == pos_q) begin
                data_d = rdata_q;
              end else begin
                we    = 1'b1;
                waddr = paddr_q - 1'b1;
              end
              if (!more_q) begin
                done_d  = 1'b1;
                state_d = W_IDLE;
              end
            end
            ile_pkg::WALK_FIND: begin
              if (rdata_q == val_q) begin
                done_d  = 1'b1;
                hit_d   = 1'b1;
                idx_d   = paddr_q;
                more_d  = 1'b0;
                pend_d  = 1'b0;
                state_d = W_IDLE;
              end else if (!more_q) begin
                done_d  = 1'b1;
                state_d = W_IDLE;
              end
            end
            default: state_d = W_IDLE;
          endcase
        end
      end
      W_FINAL: begin
        we      = 1'b1;
        waddr   = pos_q;
        wdata   = val_q;
        done_d  = 1'b1;
        state_d = W_IDLE;
      end
      default: state_d = W_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      more_q  <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
      hit_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      more_q  <= more_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    rptr_q  <= rptr_d;
    stop_q  <= stop_d;
    paddr_q <= paddr_d;
    pos_q   <= pos_d;
    idx_q   <= idx_d;
    val_q   <= val_d;
    data_q  <= data_d;
  end

  assign stat_o.done = done_q;
  assign stat_o.hit  = hit_q;
  assign data_o      = data_q;
  assign idx_o       = idx_q;

  // a shift never reads the entry it overwrites in the same cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (we && re) |-> (waddr != raddr))
    else $error("read and write hit the same entry");

  a_go_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i |-> (state_q == W_IDLE))
    else $error("walk started while busy");

  a_hit_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_q |-> done_q)
    else $error("hit without completion");

  a_final_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == W_FINAL) |-> (op_q == ile_pkg::WALK_INSERT))
    else $error("final write outside an insert");

endmodule

[src/indexed_list_engine_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed list engine core
// ordered list of signed words with get, insert, find, remove and clear
// ----------------------------------------------------------------------------
//  channel   ports                 direction  transaction
//  command   start, busy, req_i    in         start high while busy low
//  result    res_valid_o, res_o    out        one cycle, res_valid_o high
//
//  checks that fail, clear and unused kinds: result the cycle after the accept
//  get: the walk reads the entry, then the result is registered
//  insert at p with count c: entries c-1 down to p move up, then p is written
//  remove: entries p+1 to c-1 move down; find: walk ends at the first match
//  the walk runs one entry a cycle through the single-port-read entry memory
//  after reset the list is empty; the result cannot be held off
// ----------------------------------------------------------------------------
module indexed_list_engine_core #(
  parameter int CAPACITY = ile_pkg::CapacityDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  ile_pkg::ile_req_t req_i,
  output logic              res_valid_o,
  output ile_pkg::ile_res_t res_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = (CW > 7) ? CW : 7;
  localparam int IW = (AW > 6) ? AW : 6;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [2:0]    kind_q, kind_d;
  logic          res_valid_q, res_valid_d;
  logic [2:0]    status_q, status_d;
  logic [31:0]   data_q, data_d;
  logic [5:0]    found_q, found_d;

  logic               accept;
  logic               go;
  ile_pkg::ile_walk_e wop;
  logic [PW-1:0]      pos_ext, cnt_ext, cnt_q_ext;
  logic [IW-1:0]      idx_ext;
  logic               neg;

  ile_pkg::ile_stat_t walk_stat;
  logic [31:0]        walk_data;
  logic [AW-1:0]      walk_idx;

  assign accept  = start && !busy_q;
  assign pos_ext = PW'(req_i.position);
  assign cnt_ext = PW'(cnt_q);
  assign neg     = req_i.value[31];
  assign idx_ext = IW'(walk_idx);

  always_comb begin
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    kind_d      = kind_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    data_d      = data_q;
    found_d     = found_q;
    go          = 1'b0;
    wop         = ile_pkg::WALK_READ;
    if (accept) begin
      kind_d      = req_i.kind;
      res_valid_d = 1'b1;
      status_d    = ile_pkg::STATUS_OK;
      data_d      = '0;
      found_d     = '0;
      unique case (req_i.kind)
        ile_pkg::KIND_GET: begin
          if (pos_ext >= cnt_ext) begin
            status_d = ile_pkg::STATUS_RANGE;
          end else begin
            go = 1'b1;
          end
        end
        ile_pkg::KIND_INSERT: begin
          if (pos_ext > cnt_ext) begin
            status_d = ile_pkg::STATUS_RANGE;
          end else if (neg) begin
            status_d = ile_pkg::STATUS_NEG;
          end else if (cnt_ext >= PW'(CAPACITY)) begin
            status_d = ile_pkg::STATUS_FULL;
          end else begin
            go    = 1'b1;
            wop   = ile_pkg::WALK_INSERT;
            cnt_d = cnt_q + 1'b1;
          end
        end
        ile_pkg::KIND_FIND: begin
          if (neg) begin
            status_d = ile_pkg::STATUS_NEG;
          end else begin
            go  = 1'b1;
            wop = ile_pkg::WALK_FIND;
          end
        end
        ile_pkg::KIND_REMOVE: begin
          if (pos_ext >= cnt_ext) begin
            status_d = ile_pkg::STATUS_RANGE;
          end else begin
            go    = 1'b1;
            wop   = ile_pkg::WALK_REMOVE;
            cnt_d = cnt_q - 1'b1;
          end
        end
        ile_pkg::KIND_CLEAR: cnt_d = '0;
        default: cnt_d = cnt_q;
      endcase
      // walked operations report when the walk finishes
      if (go) begin
        res_valid_d = 1'b0;
      end
      busy_d = go;
    end else if (walk_stat.done) begin
      busy_d      = 1'b0;
      res_valid_d = 1'b1;
      status_d    = ile_pkg::STATUS_OK;
      data_d      = '0;
      found_d     = '0;
      if (kind_q == ile_pkg::KIND_FIND && !walk_stat.hit) begin
        status_d = ile_pkg::STATUS_MISSING;
      end
      if (kind_q == ile_pkg::KIND_GET || kind_q == ile_pkg::KIND_REMOVE) begin
        data_d = walk_data;
      end
      if (walk_stat.hit) begin
        found_d = idx_ext[5:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    status_q <= status_d;
    data_q   <= data_d;
    found_q  <= found_d;
  end

  ile_walk #(
    .CAPACITY (CAPACITY)
  ) u_walk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (go),
    .op_i    (wop),
    .pos_i   (pos_ext[AW-1:0]),
    .cnt_i   (cnt_q),
    .value_i (req_i.value),
    .stat_o  (walk_stat),
    .data_o  (walk_data),
    .idx_o   (walk_idx)
  );

  // count is already updated while the result is shown
  assign cnt_q_ext         = PW'(cnt_q);
  assign busy              = busy_q;
  assign res_valid_o       = res_valid_q;
  assign res_o.status      = status_q;
  assign res_o.data        = data_q;
  assign res_o.found_at    = found_q;
  assign res_o.count_after = cnt_q_ext[6:0];

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("count beyond capacity");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.done |-> busy_q)
    else $error("walk finished while not busy");

  a_done_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walk_stat.done |=> (res_valid_q && !busy_q))
    else $error("walk completion gave no result");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed list engine testbench
// drives get, insert, find, remove, clear and spare kinds with random gaps and
// compares every result with a predicted copy of the list, field by field
// ----------------------------------------------------------------------------
module tb_top;

  localparam int Cap = ile_pkg::CapacityDef;
  localparam logic [2:0] KIND_LAST = 3'd7;
  localparam int RandomItems = 600;
  localparam int SettleCycles = 80;

  typedef enum int {MIX_GROW, MIX_EVEN, MIX_SHRINK} mix_e;

  class list_scoreboard;
    logic signed [31:0] entries [Cap];
    int                 count;
    ile_pkg::ile_res_t  pending_results [$];
    int                 failures;

    function void clear_state();
      count = 0;
      failures = 0;
      pending_results.delete();
    endfunction

    // update the predicted list for one accepted command and queue its result
    function void note_command(ile_pkg::ile_req_t r);
      ile_pkg::ile_res_t e;
      int                i;
      e = '0;
      case (r.kind)
        ile_pkg::KIND_GET: begin
          if (r.position >= count) e.status = ile_pkg::STATUS_RANGE;
          else e.data = entries[r.position];
        end
        ile_pkg::KIND_INSERT: begin
          if (r.position > count) e.status = ile_pkg::STATUS_RANGE;
          else if (r.value[31]) e.status = ile_pkg::STATUS_NEG;
          else if (count >= Cap || r.position >= Cap) e.status = ile_pkg::STATUS_FULL;
          else begin
            for (i = count; i > r.position; i--) entries[i] = entries[i - 1];
            entries[r.position] = r.value;
            count++;
          end
        end
        ile_pkg::KIND_FIND: begin
          if (r.value[31]) e.status = ile_pkg::STATUS_NEG;
          else begin
            e.status = ile_pkg::STATUS_MISSING;
            for (i = 0; i < count; i++) begin
              if (entries[i] == r.value) begin
                e.status = ile_pkg::STATUS_OK;
                e.found_at = i[5:0];
                break;
              end
            end
          end
        end
        ile_pkg::KIND_REMOVE: begin
          if (r.position >= count) e.status = ile_pkg::STATUS_RANGE;
          else begin
            e.data = entries[r.position];
            for (i = r.position; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
          end
        end
        ile_pkg::KIND_CLEAR: count = 0;
        default: ;
      endcase
      e.count_after = count[6:0];
      pending_results.push_back(e);
    endfunction

    function void check_result(ile_pkg::ile_res_t r);
      ile_pkg::ile_res_t e;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: status %0d data %0d", r.status, r.data);
        failures++;
        return;
      end
      e = pending_results.pop_front();
      if (r.status !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, r.status);
        failures++;
      end
      if (r.data !== e.data) begin
        $error("data: expected %0d, actual %0d", e.data, r.data);
        failures++;
      end
      if (r.found_at !== e.found_at) begin
        $error("found_at: expected %0d, actual %0d", e.found_at, r.found_at);
        failures++;
      end
      if (r.count_after !== e.count_after) begin
        $error("count_after: expected %0d, actual %0d", e.count_after, r.count_after);
        failures++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  ile_pkg::ile_req_t req_i;
  logic              res_valid_o;
  ile_pkg::ile_res_t res_o;

  list_scoreboard board;

  indexed_list_engine_core #(
    .CAPACITY(Cap)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) board.check_result(res_o);
  end

  // start stays high across back-to-back commands, lowered only for a gap
  task automatic send_command(input ile_pkg::ile_req_t r);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_command(r);
  endtask

  task automatic issue(input logic [2:0] kind, input int pos, input logic [31:0] val);
    ile_pkg::ile_req_t r;
    r.kind = kind;
    r.position = pos[6:0];
    r.value = val;
    send_command(r);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (board.pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [6:0] pick_position(int limit);
    if ($urandom_range(0, 99) < 85) return 7'($urandom_range(0, limit));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [31:0] pick_value(bit for_find);
    int roll;
    roll = $urandom_range(0, 99);
    if (for_find && board.count > 0 && roll < 60)
      return board.entries[$urandom_range(0, board.count - 1)];
    if (roll < 65) return 32'($urandom_range(0, 15));
    if (roll < 85) return $urandom & 32'h7fff_ffff;
    if (roll < 95) return $urandom;
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  function automatic ile_pkg::ile_req_t make_command(mix_e mix);
    ile_pkg::ile_req_t r;
    int                roll;
    int                ins_w;
    int                rem_w;
    case (mix)
      MIX_GROW:   begin ins_w = 55; rem_w = 10; end
      MIX_SHRINK: begin ins_w = 10; rem_w = 50; end
      default:    begin ins_w = 30; rem_w = 25; end
    endcase
    roll = $urandom_range(0, 99);
    r.position = pick_position(board.count == 0 ? 0 : board.count - 1);
    r.value = pick_value(1'b0);
    if (roll < 3) begin
      r.kind = 3'($urandom_range(ile_pkg::KIND_CLEAR + 1, KIND_LAST));
      r.position = 7'($urandom_range(0, 127));
      r.value = $urandom;
    end else if (roll < 5) begin
      r.kind = ile_pkg::KIND_CLEAR;
    end else if (roll < 5 + ins_w) begin
      r.kind = ile_pkg::KIND_INSERT;
      r.position = pick_position(board.count);
    end else if (roll < 5 + ins_w + rem_w) begin
      r.kind = ile_pkg::KIND_REMOVE;
    end else if (roll % 2 == 0) begin
      r.kind = ile_pkg::KIND_GET;
    end else begin
      r.kind = ile_pkg::KIND_FIND;
      r.value = pick_value(1'b1);
    end
    return r;
  endfunction

  initial begin
    int                sent;
    int                len;
    int                k;
    mix_e              mix;
    ile_pkg::ile_req_t r;

    board = new();
    board.clear_state();
    rst_ni <= 1'b0;
    start <= 1'b0;
    req_i <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty list, insert checks, duplicates, range edges, spare kinds
    issue(ile_pkg::KIND_GET, 0, 32'd0);
    issue(ile_pkg::KIND_REMOVE, 0, 32'd0);
    issue(ile_pkg::KIND_FIND, 0, 32'd5);
    issue(ile_pkg::KIND_INSERT, 1, 32'd5);
    issue(ile_pkg::KIND_INSERT, 0, 32'hffff_ffff);
    issue(ile_pkg::KIND_INSERT, 0, 32'h7fff_ffff);
    issue(ile_pkg::KIND_INSERT, 0, 32'd0);
    issue(ile_pkg::KIND_INSERT, 2, 32'd7);
    issue(ile_pkg::KIND_INSERT, 1, 32'd7);
    issue(ile_pkg::KIND_FIND, 0, 32'd7);
    issue(ile_pkg::KIND_FIND, 0, 32'h7fff_ffff);
    issue(ile_pkg::KIND_FIND, 0, 32'd3);
    issue(ile_pkg::KIND_FIND, 0, 32'h8000_0000);
    issue(ile_pkg::KIND_GET, 3, 32'd0);
    issue(ile_pkg::KIND_GET, 4, 32'd0);
    issue(ile_pkg::KIND_GET, 127, 32'd0);
    issue(ile_pkg::KIND_REMOVE, 127, 32'd0);
    issue(ile_pkg::KIND_REMOVE, 1, 32'd0);
    issue(ile_pkg::KIND_REMOVE, 2, 32'd0);
    for (k = ile_pkg::KIND_CLEAR + 1; k <= KIND_LAST; k++) issue(k[2:0], 127, 32'hffff_ffff);
    issue(ile_pkg::KIND_CLEAR, 0, 32'd0);
    issue(ile_pkg::KIND_GET, 0, 32'd0);
    issue(ile_pkg::KIND_CLEAR, 127, 32'hffff_ffff);
    wait_drained();

    // fill to capacity, then push against the full list
    sent = 0;
    while (board.count < Cap) begin
      issue(ile_pkg::KIND_INSERT, $urandom_range(0, board.count),
            pick_value(1'b0) & 32'h7fff_ffff);
      sent++;
    end
    issue(ile_pkg::KIND_INSERT, Cap, 32'd1);
    issue(ile_pkg::KIND_INSERT, 0, 32'd1);
    issue(ile_pkg::KIND_INSERT, 0, 32'h8000_0000);
    issue(ile_pkg::KIND_GET, Cap - 1, 32'd0);
    issue(ile_pkg::KIND_REMOVE, Cap - 1, 32'd0);
    issue(ile_pkg::KIND_REMOVE, 0, 32'd0);
    sent += 6;
    wait_drained();

    while (sent < RandomItems) begin
      mix = mix_e'($urandom_range(0, 2));
      len = $urandom_range(20, 90);
      repeat (len) begin
        r = make_command(mix);
        send_command(r);
        sent++;
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
    end
    start <= 1'b0;

    while (board.pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (board.failures == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
src/ile_pkg.sv
src/ile_walk.sv
src/indexed_list_engine_core.sv
bench/tb_top.sv
